/* hw/rtl/stable_priority_queue_defines.svh */
// Assertion macros for the stable priority queue.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define SPQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
// No dependencies; imported by spq_cell and stable_priority_queue.
package spq_pkg;

	localparam int ID_W   = 16;
	localparam int PRIO_W = 8;
	localparam int STAT_W = 2;

	typedef enum logic [0:0] {
		FUNC_ENQ = 1'b0,
		FUNC_DEQ = 1'b1
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic              enq;
		logic              deq;
		logic [PRIO_W-1:0] prio;
	} spq_ctl_t;

endpackage

/* hw/rtl/spq_cell.sv */
// One storage cell of the sorted queue chain: holds one entry.
// Depends on spq_pkg; instantiated in a row by stable_priority_queue.
module spq_cell #(
	parameter int IDX         = 0,
	parameter int HANDLE_BITS = 16,
	parameter int CNT_W       = 5
) (
	input  logic                      clk,
	input  spq_pkg::spq_ctl_t         ctl,
	input  logic [CNT_W-1:0]          count,
	input  logic [HANDLE_BITS-1:0]    new_actor,
	input  logic [HANDLE_BITS-1:0]    new_message,
	input  logic                      left_stay,
	input  logic [HANDLE_BITS-1:0]    left_actor,
	input  logic [HANDLE_BITS-1:0]    left_message,
	input  logic [spq_pkg::PRIO_W-1:0] left_prio,
	input  logic [HANDLE_BITS-1:0]    right_actor,
	input  logic [HANDLE_BITS-1:0]    right_message,
	input  logic [spq_pkg::PRIO_W-1:0] right_prio,
	output logic                      stay,
	output logic [HANDLE_BITS-1:0]    actor,
	output logic [HANDLE_BITS-1:0]    message,
	output logic [spq_pkg::PRIO_W-1:0] prio
);
	import spq_pkg::*;

	logic [HANDLE_BITS-1:0] actor_q;
	logic [HANDLE_BITS-1:0] message_q;
	logic [PRIO_W-1:0]      prio_q;
	logic                   occupied;

	assign occupied = (CNT_W'(IDX) < count);
	assign stay     = occupied && (prio_q <= ctl.prio);

	always_ff @(posedge clk) begin
		if (ctl.enq && !stay) begin
			// insert here at the boundary, shift right behind it
			if (left_stay) begin
				actor_q   <= new_actor;
				message_q <= new_message;
				prio_q    <= ctl.prio;
			end else begin
				actor_q   <= left_actor;
				message_q <= left_message;
				prio_q    <= left_prio;
			end
		end else if (ctl.deq) begin
			actor_q   <= right_actor;
			message_q <= right_message;
			prio_q    <= right_prio;
		end
	end

	assign actor   = actor_q;
	assign message = message_q;
	assign prio    = prio_q;

endmodule

/* hw/rtl/stable_priority_queue.sv */
// Top level of the stable priority queue: cell chain, count and result registers.
// Depends on spq_pkg, spq_cell and stable_priority_queue_defines.svh.
//
// Takes one enqueue or dequeue in every cycle: busy stays low, and the result
// of an item shows on the result ports, with done high, for the single cycle
// right after the item is accepted. The receiver cannot stall, so each result
// must be captured in that cycle. All CAPACITY cells update together in the same
// cycle: each cell compares its own priority against the new one and, with
// its left neighbor's flag, decides whether to hold, take the new entry, take
// the left entry (enqueue) or take the right entry (dequeue). Entries of equal
// priority leave in arrival order. An enqueue on a full queue is dropped with
// status full; a dequeue on an empty queue returns status empty.
module stable_priority_queue #(
	parameter int CAPACITY    = 16,
	parameter int HANDLE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                func,
	input  logic [spq_pkg::ID_W-1:0]            actor_id,
	input  logic [spq_pkg::ID_W-1:0]            message_id,
	input  logic [spq_pkg::PRIO_W-1:0]          priority_req,
	output logic                                done,
	output logic [spq_pkg::STAT_W-1:0]          status,
	output logic [spq_pkg::ID_W-1:0]            deq_actor,
	output logic [spq_pkg::ID_W-1:0]            out_message,
	output logic [spq_pkg::PRIO_W-1:0]          out_priority,
	output logic [$clog2(CAPACITY+1)-1:0]       entry_count
);
	import spq_pkg::*;

	`include "stable_priority_queue_defines.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic                   accept;
	logic                   is_deq;
	logic                   full;
	logic                   empty;
	spq_ctl_t               ctl;
	logic [HANDLE_BITS-1:0] new_actor;
	logic [HANDLE_BITS-1:0] new_message;

	logic [CNT_W-1:0]       count_q;
	logic                   done_q;
	status_t                status_q;
	logic [ID_W-1:0]        actor_q;
	logic [ID_W-1:0]        message_q;
	logic [PRIO_W-1:0]      prio_q;

	logic                   cell_stay    [CAPACITY];
	logic [HANDLE_BITS-1:0] cell_actor   [CAPACITY];
	logic [HANDLE_BITS-1:0] cell_message [CAPACITY];
	logic [PRIO_W-1:0]      cell_prio    [CAPACITY];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign is_deq = (func_t'(func) == FUNC_DEQ);
	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);

	assign ctl.enq  = accept && !is_deq && !full;
	assign ctl.deq  = accept && is_deq && !empty;
	assign ctl.prio = priority_req;

	assign new_actor   = HANDLE_BITS'(actor_id);
	assign new_message = HANDLE_BITS'(message_id);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                   l_stay;
		logic [HANDLE_BITS-1:0] l_actor, l_message, r_actor, r_message;
		logic [PRIO_W-1:0]      l_prio, r_prio;

		if (i == 0) begin : g_head
			assign l_stay    = 1'b1;
			assign l_actor   = new_actor;
			assign l_message = new_message;
			assign l_prio    = priority_req;
		end else begin : g_body
			assign l_stay    = cell_stay[i-1];
			assign l_actor   = cell_actor[i-1];
			assign l_message = cell_message[i-1];
			assign l_prio    = cell_prio[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_actor   = cell_actor[i];
			assign r_message = cell_message[i];
			assign r_prio    = cell_prio[i];
		end else begin : g_mid
			assign r_actor   = cell_actor[i+1];
			assign r_message = cell_message[i+1];
			assign r_prio    = cell_prio[i+1];
		end

		spq_cell #(
			.IDX         (i),
			.HANDLE_BITS (HANDLE_BITS),
			.CNT_W       (CNT_W)
		) u_cell (
			.clk           (clk),
			.ctl           (ctl),
			.count         (count_q),
			.new_actor     (new_actor),
			.new_message   (new_message),
			.left_stay     (l_stay),
			.left_actor    (l_actor),
			.left_message  (l_message),
			.left_prio     (l_prio),
			.right_actor   (r_actor),
			.right_message (r_message),
			.right_prio    (r_prio),
			.stay          (cell_stay[i]),
			.actor         (cell_actor[i]),
			.message       (cell_message[i]),
			.prio          (cell_prio[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (ctl.enq) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end else if (ctl.deq) begin
				count_q <= CNT_W'(count_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			actor_q   <= '0;
			message_q <= '0;
			prio_q    <= '0;
			if (is_deq) begin
				if (empty) begin
					status_q <= ST_EMPTY;
				end else begin
					status_q  <= ST_OK;
					actor_q   <= ID_W'(cell_actor[0]);
					message_q <= ID_W'(cell_message[0]);
					prio_q    <= cell_prio[0];
				end
			end else begin
				status_q <= full ? ST_FULL : ST_OK;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign deq_actor    = actor_q;
	assign out_message  = message_q;
	assign out_priority = prio_q;
	assign entry_count  = count_q;

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY), "count above capacity")
	`SPQ_ASSERT_NEXT(a_enq_count, ctl.enq, count_q == CNT_W'($past(count_q) + 1'b1), "enqueue count")
	`SPQ_ASSERT_NOW(a_full_count, done && status == ST_FULL, entry_count == CNT_W'(CAPACITY), "full status with room left")
	`SPQ_ASSERT_NEXT(a_empty_deq, accept && is_deq && empty, done && status == ST_EMPTY, "empty dequeue result")
	`SPQ_ASSERT_NOW(a_head_order, count_q >= CNT_W'(2), cell_prio[0] <= cell_prio[1], "head out of order")

endmodule
